/* hdl/affine_2d_transform_engine_assert.svh */
// assertion macros shared by the affine engine
`ifndef AFFINE_2D_TRANSFORM_ENGINE_ASSERT_SVH
`define AFFINE_2D_TRANSFORM_ENGINE_ASSERT_SVH

// same-cycle implication
`define A2T_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a2t check failed");

// next-cycle implication
`define A2T_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a2t check failed");

`endif

/* hdl/a2t_pkg.sv */
package a2t_pkg;

    typedef enum logic [2:0] {
        REQ_IDENTITY  = 3'd0,
        REQ_TRANSLATE = 3'd1,
        REQ_ROTATE    = 3'd2,
        REQ_SCALE     = 3'd3,
        REQ_VERTEX    = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CORD,
        S_MUL,
        S_ACC,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_PREP,
        PH_COMP,
        PH_VERT
    } phase_t;

    localparam int ACC_W = 52;
    localparam int OPD_W = 33;
    localparam int PRD_W = 2 * OPD_W;
    localparam int CRD_W = 34;
    localparam int ZW    = 36;
    localparam int MAX_STEPS = 24;

    localparam logic signed [OPD_W-1:0] ONE_Q16   = 33'sd65536;
    localparam logic signed [CRD_W-1:0] GAIN_Q30  = 34'sd652032874;
    localparam logic signed [ZW-1:0]    HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZW-1:0]    PI_Q30    = 36'sd3373259426;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd843314856;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525158;
            5'd4:  r = 30'd67021686;
            5'd5:  r = 30'd33543515;
            5'd6:  r = 30'd16775850;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194282;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048575;
            5'd11: r = 30'd524287;
            5'd12: r = 30'd262143;
            5'd13: r = 30'd131071;
            5'd14: r = 30'd65535;
            5'd15: r = 30'd32767;
            5'd16: r = 30'd16383;
            5'd17: r = 30'd8191;
            5'd18: r = 30'd4095;
            5'd19: r = 30'd2047;
            5'd20: r = 30'd1023;
            5'd21: r = 30'd511;
            5'd22: r = 30'd255;
            5'd23: r = 30'd127;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // clamp to signed 32 bits, bit 32 of the result is the clamp flag
    function automatic logic [32:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [32:0] r;
        if (v > 52'sd2147483647)
            r = {1'b1, 32'h7fff_ffff};
        else if (v < -52'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

/* hdl/affine_2d_transform_engine.sv */
// throughput: one request at a time, set by the shared 33x33 multiplier (12 products per
// composition) and the one-step-per-cycle CORDIC loop of CORDIC_STEPS (max 24) steps
// reset: matrix goes to identity and the sticky flag clears, output register empties
module affine_2d_transform_engine #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] arg_x,
    input  logic signed [31:0] arg_y,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [15:0] angle,
    input  logic               batch_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic               batch_end,
    output logic               saturated
);
    import a2t_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [2:0] req_reg, req_next;
    logic [2:0] ent_reg, ent_next;
    logic       term_reg, term_next;
    logic [4:0] iter_reg, iter_next;
    logic       neg_reg, neg_next;
    logic       sticky_reg, sticky_next;
    logic       vflag_reg, vflag_next;
    logic       last_reg, last_next;
    logic       ovalid_reg, ovalid_next;
    logic signed [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] ox_reg, ox_next, oy_reg, oy_next;
    logic signed [31:0] rx_reg, rx_next, ry_reg, ry_next;
    logic               rend_reg, rend_next, rsat_reg, rsat_next;
    logic signed [CRD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0]    z_reg, z_next;
    logic signed [PRD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0]    m_reg [6];
    logic signed [31:0]    m_next [6];
    logic signed [31:0]    n_reg [6];
    logic signed [31:0]    n_next [6];
    logic signed [OPD_W-1:0] a_reg [6];
    logic signed [OPD_W-1:0] a_next [6];

    // operand selection
    logic signed [OPD_W-1:0] opa, opb;
    logic signed [31:0]      addend;
    logic                    sub, tlast, elast;

    always_comb
    begin
        logic [2:0] ra;
        logic [2:0] rb;
        ra     = 3'd0;
        rb     = 3'd0;
        opa    = '0;
        opb    = '0;
        addend = '0;
        sub    = 1'b0;
        tlast  = term_reg;
        elast  = 1'b0;
        case (phase_reg)
            PH_PREP:
            begin
                elast = (ent_reg == 3'd1);
                if (req_reg == REQ_ROTATE) begin
                    if (ent_reg == 3'd0) begin
                        opa = term_reg ? 33'(py_reg) : 33'(px_reg);
                        opb = term_reg ? a_reg[3] : ONE_Q16 - a_reg[0];
                    end else begin
                        opa = term_reg ? 33'(px_reg) : 33'(py_reg);
                        opb = term_reg ? a_reg[3] : ONE_Q16 - a_reg[0];
                        sub = term_reg;
                    end
                end else begin
                    tlast = 1'b1;
                    opa   = (ent_reg == 3'd0) ? ONE_Q16 - 33'(ax_reg) : ONE_Q16 - 33'(ay_reg);
                    opb   = (ent_reg == 3'd0) ? 33'(px_reg) : 33'(py_reg);
                end
            end
            PH_COMP:
            begin
                elast = (ent_reg == 3'd5);
                case (ent_reg)
                    3'd0: begin ra = 3'd0; rb = 3'd0; end
                    3'd1: begin ra = 3'd0; rb = 3'd1; end
                    3'd2: begin ra = 3'd0; rb = 3'd2; end
                    3'd3: begin ra = 3'd3; rb = 3'd0; end
                    3'd4: begin ra = 3'd3; rb = 3'd1; end
                    default: begin ra = 3'd3; rb = 3'd2; end
                endcase
                opa = a_reg[ra + 3'(term_reg)];
                opb = 33'(m_reg[rb + (term_reg ? 3'd3 : 3'd0)]);
                if (rb == 3'd2)
                    addend = a_reg[ra + 3'd2][31:0];
            end
            default:
            begin
                elast  = (ent_reg == 3'd1);
                ra     = (ent_reg == 3'd0) ? 3'd0 : 3'd3;
                opa    = 33'(m_reg[ra + 3'(term_reg)]);
                opb    = term_reg ? 33'(ay_reg) : 33'(ax_reg);
                addend = m_reg[ra + 3'd2];
            end
        endcase
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] term, total;
        logic [32:0]             st;
        logic signed [ZW-1:0]    z0;
        logic signed [ZW-1:0]    at;
        logic signed [CRD_W-1:0] xs, ys, cc, ss;
        state_next  = state_reg;
        phase_next  = phase_reg;
        req_next    = req_reg;
        ent_next    = ent_reg;
        term_next   = term_reg;
        iter_next   = iter_reg;
        neg_next    = neg_reg;
        sticky_next = sticky_reg;
        vflag_next  = vflag_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg;
        ax_next = ax_reg; ay_next = ay_reg; px_next = px_reg; py_next = py_reg;
        ox_next = ox_reg; oy_next = oy_reg;
        rx_next = rx_reg; ry_next = ry_reg; rend_next = rend_reg; rsat_next = rsat_reg;
        cx_next = cx_reg; cy_next = cy_reg; z_next = z_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        m_next = m_reg;
        n_next = n_reg;
        a_next = a_reg;
        term  = ACC_W'($signed(prod_reg[PRD_W-1:16]));
        total = '0;
        st    = '0;
        z0    = ZW'(angle) <<< 17;
        at    = ZW'(atan_q30(iter_reg));
        xs    = cx_reg >>> iter_reg;
        ys    = cy_reg >>> iter_reg;
        cc    = cx_reg >>> 14;
        ss    = cy_reg >>> 14;

        if (out_valid && out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    req_next = req_type;
                    ax_next = arg_x; ay_next = arg_y;
                    px_next = point_x; py_next = point_y;
                    last_next  = batch_last;
                    vflag_next = 1'b0;
                    ent_next   = '0;
                    term_next  = 1'b0;
                    acc_next   = '0;
                    case (req_type)
                        REQ_IDENTITY:
                        begin
                            m_next[0] = 32'sd65536; m_next[1] = '0; m_next[2] = '0;
                            m_next[3] = '0; m_next[4] = 32'sd65536; m_next[5] = '0;
                            sticky_next = 1'b0;
                        end
                        REQ_TRANSLATE:
                        begin
                            a_next[0] = ONE_Q16; a_next[1] = '0; a_next[2] = 33'(arg_x);
                            a_next[3] = '0; a_next[4] = ONE_Q16; a_next[5] = 33'(arg_y);
                            phase_next = PH_COMP;
                            state_next = S_MUL;
                        end
                        REQ_ROTATE:
                        begin
                            // fold beyond plus or minus pi/2, negate the results later
                            neg_next = 1'b0;
                            z_next   = z0;
                            if (z0 > HALF_PI_Q30) begin
                                z_next = z0 - PI_Q30; neg_next = 1'b1;
                            end else if (z0 < -HALF_PI_Q30) begin
                                z_next = z0 + PI_Q30; neg_next = 1'b1;
                            end
                            cx_next    = GAIN_Q30;
                            cy_next    = '0;
                            iter_next  = '0;
                            state_next = S_CORD;
                        end
                        REQ_SCALE:
                        begin
                            a_next[0] = 33'(arg_x); a_next[1] = '0;
                            a_next[3] = '0; a_next[4] = 33'(arg_y);
                            phase_next = PH_PREP;
                            state_next = S_MUL;
                        end
                        REQ_VERTEX:
                        begin
                            phase_next = PH_VERT;
                            state_next = S_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            S_CORD:
            begin
                if (iter_reg == 5'(NSTEPS)) begin
                    a_next[0] = neg_reg ? 33'(-cc) : 33'(cc);
                    a_next[4] = neg_reg ? 33'(-cc) : 33'(cc);
                    a_next[3] = neg_reg ? 33'(-ss) : 33'(ss);
                    a_next[1] = neg_reg ? 33'(ss) : 33'(-ss);
                    phase_next = PH_PREP;
                    state_next = S_MUL;
                end else begin
                    if (!z_reg[ZW-1]) begin
                        cx_next = cx_reg - ys;
                        cy_next = cy_reg + xs;
                        z_next  = z_reg - at;
                    end else begin
                        cx_next = cx_reg + ys;
                        cy_next = cy_reg - xs;
                        z_next  = z_reg + at;
                    end
                    iter_next = iter_reg + 5'd1;
                end
            end
            S_MUL:
            begin
                prod_next  = opa * opb;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                total = sub ? acc_reg - term : acc_reg + term;
                if (!tlast) begin
                    acc_next   = total;
                    term_next  = 1'b1;
                    state_next = S_MUL;
                end else begin
                    total      = total + ACC_W'(addend);
                    st         = sat32(total);
                    acc_next   = '0;
                    term_next  = 1'b0;
                    ent_next   = ent_reg + 3'd1;
                    state_next = S_MUL;
                    case (phase_reg)
                        PH_PREP:
                        begin
                            if (st[32])
                                sticky_next = 1'b1;
                            if (ent_reg == 3'd0)
                                a_next[2] = 33'($signed(st[31:0]));
                            else
                                a_next[5] = 33'($signed(st[31:0]));
                            if (elast) begin
                                ent_next   = '0;
                                phase_next = PH_COMP;
                            end
                        end
                        PH_COMP:
                        begin
                            if (st[32])
                                sticky_next = 1'b1;
                            n_next[ent_reg] = st[31:0];
                            if (elast) begin
                                m_next     = n_reg;
                                m_next[5]  = st[31:0];
                                state_next = S_IDLE;
                            end
                        end
                        default:
                        begin
                            if (st[32])
                                vflag_next = 1'b1;
                            if (elast) begin
                                oy_next    = st[31:0];
                                state_next = S_DONE;
                            end else begin
                                ox_next = st[31:0];
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                // wait for the output register to free up
                if (!out_valid || out_ready) begin
                    rx_next     = ox_reg;
                    ry_next     = oy_reg;
                    rend_next   = last_reg;
                    rsat_next   = vflag_reg | sticky_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_PREP;
            ent_reg    <= '0;
            term_reg   <= 1'b0;
            iter_reg   <= '0;
            sticky_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            m_reg[0] <= 32'sd65536; m_reg[1] <= '0; m_reg[2] <= '0;
            m_reg[3] <= '0; m_reg[4] <= 32'sd65536; m_reg[5] <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            ent_reg    <= ent_next;
            term_reg   <= term_next;
            iter_reg   <= iter_next;
            sticky_reg <= sticky_next;
            ovalid_reg <= ovalid_next;
            m_reg      <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        neg_reg <= neg_next;
        vflag_reg <= vflag_next;
        last_reg <= last_next;
        ax_reg <= ax_next; ay_reg <= ay_next; px_reg <= px_next; py_reg <= py_next;
        ox_reg <= ox_next; oy_reg <= oy_next;
        rx_reg <= rx_next; ry_reg <= ry_next; rend_reg <= rend_next; rsat_reg <= rsat_next;
        cx_reg <= cx_next; cy_reg <= cy_next; z_reg <= z_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        n_reg <= n_next;
        a_reg <= a_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_x     = rx_reg;
    assign out_y     = ry_reg;
    assign batch_end = rend_reg;
    assign saturated = rsat_reg;

`include "affine_2d_transform_engine_assert.svh"

    `A2T_ASSERT_NOW(a_cord_bound, state_reg == S_CORD, iter_reg <= 5'(NSTEPS))
    `A2T_ASSERT_NOW(a_load_from_done, $rose(out_valid), $past(state_reg == S_DONE))
    `A2T_ASSERT_NEXT(a_identity, in_valid && in_ready && req_type == REQ_IDENTITY,
        m_reg[0] == 32'sd65536 && m_reg[1] == 32'sd0 && !sticky_reg)

endmodule

/* tb/sv/affine_2d_transform_engine_tb.sv */
`timescale 1ns / 100ps

module affine_2d_transform_engine_tb;
    import a2t_pkg::*;

    localparam int STEPS = 16;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
        logic               sat;
    } vertex_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         req_type;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [15:0] angle;
    logic               batch_last;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               batch_end;
    logic               saturated;

    // predicted state of the block
    longint  mat [6];
    bit      sticky;
    vertex_t vertex_q [$];

    int errors;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int n_sent;
    int n_checked;
    int n_sat;

    affine_2d_transform_engine #(.CORDIC_STEPS(STEPS)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .arg_x(arg_x), .arg_y(arg_y),
        .point_x(point_x), .point_y(point_y), .angle(angle),
        .batch_last(batch_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .batch_end(batch_end), .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint clamp32(longint v, ref bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint arctan_step(int i);
        longint t [24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127};
        return t[i];
    endfunction

    task automatic sin_cos(input logic signed [15:0] ang, output longint c,
                           output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'(ang) * 131072;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713)
        begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end
        else if (z < -64'sd1686629713)
        begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_step(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_step(i);
            end
            x = nx;
        end
        x = x >>> 14;
        y = y >>> 14;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic compose(input longint a [6]);
        longint n [6];
        bit     f;
        f = 1'b0;
        for (int r = 0; r < 2; r++)
        begin
            n[r*3]   = clamp32(qmul(a[r*3], mat[0]) + qmul(a[r*3+1], mat[3]), f);
            n[r*3+1] = clamp32(qmul(a[r*3], mat[1]) + qmul(a[r*3+1], mat[4]), f);
            n[r*3+2] = clamp32(qmul(a[r*3], mat[2]) + qmul(a[r*3+1], mat[5])
                               + a[r*3+2], f);
        end
        mat = n;
        if (f)
            sticky = 1'b1;
    endtask

    task automatic load_identity();
        mat = '{65536, 0, 0, 0, 65536, 0};
        sticky = 1'b0;
    endtask

    task automatic predict(input logic [2:0] rq, input logic signed [31:0] ax,
                           input logic signed [31:0] ay, input logic signed [31:0] px,
                           input logic signed [31:0] py, input logic signed [15:0] ang,
                           input logic bl);
        longint  a [6];
        longint  c;
        longint  s;
        bit      f;
        vertex_t v;
        f = 1'b0;
        case (rq)
            REQ_IDENTITY:
                load_identity();
            REQ_TRANSLATE:
            begin
                a = '{65536, 0, longint'(ax), 0, 65536, longint'(ay)};
                compose(a);
            end
            REQ_ROTATE:
            begin
                sin_cos(ang, c, s);
                a[0] = c;
                a[1] = -s;
                a[2] = clamp32(qmul(longint'(px), 65536 - c) + qmul(longint'(py), s), f);
                a[3] = s;
                a[4] = c;
                a[5] = clamp32(qmul(longint'(py), 65536 - c) - qmul(longint'(px), s), f);
                if (f)
                    sticky = 1'b1;
                compose(a);
            end
            REQ_SCALE:
            begin
                a[0] = longint'(ax);
                a[1] = 0;
                a[2] = clamp32(qmul(65536 - longint'(ax), longint'(px)), f);
                a[3] = 0;
                a[4] = longint'(ay);
                a[5] = clamp32(qmul(65536 - longint'(ay), longint'(py)), f);
                if (f)
                    sticky = 1'b1;
                compose(a);
            end
            REQ_VERTEX:
            begin
                v.x = 32'(clamp32(qmul(mat[0], longint'(ax)) + qmul(mat[1], longint'(ay))
                                  + mat[2], f));
                v.y = 32'(clamp32(qmul(mat[3], longint'(ax)) + qmul(mat[4], longint'(ay))
                                  + mat[5], f));
                v.last = bl;
                v.sat = f | sticky;
                vertex_q.push_back(v);
            end
            default:
                ;
        endcase
    endtask

    task automatic send_request(input logic [2:0] rq, input logic signed [31:0] ax,
                                input logic signed [31:0] ay, input logic signed [31:0] px,
                                input logic signed [31:0] py, input logic signed [15:0] ang,
                                input logic bl);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        arg_x      <= ax;
        arg_y      <= ay;
        point_x    <= px;
        point_y    <= py;
        angle      <= ang;
        batch_last <= bl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict(rq, ax, ay, px, py, ang, bl);
        n_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (vertex_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $signed($urandom_range(262144)) - 131072;
            2: return $signed($urandom_range(65536 * 64)) - 65536 * 32;
            default: return $signed($urandom_range(65536 * 4)) - 65536 * 2;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_angle();
        if ($urandom_range(9) == 0)
            return 16'($urandom());
        return 16'($signed($urandom_range(51472)) - 25736);
    endfunction

    task automatic test_directed();
        send_request(REQ_VERTEX, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 1'b1);
        send_request(REQ_VERTEX, 32'sh0001_0000, 32'shffff_0000, 0, 0, 0, 1'b0);
        send_request(REQ_TRANSLATE, 32'sh0003_8000, -32'sh0002_0000, 0, 0, 0, 1'b1);
        send_request(REQ_VERTEX, 32'sh0001_0000, 32'sh0002_0000, 0, 0, 0, 1'b0);
        send_request(REQ_ROTATE, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 16'sd12868, 1'b0);
        send_request(REQ_VERTEX, 32'sh0001_0000, 0, 0, 0, 0, 1'b1);
        // angles past half pi fold back, extremes of the 16-bit pattern too
        send_request(REQ_ROTATE, 0, 0, 0, 0, 16'sd25736, 1'b0);
        send_request(REQ_ROTATE, 0, 0, 0, 0, -16'sd25736, 1'b0);
        send_request(REQ_ROTATE, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 16'sh7fff, 1'b0);
        send_request(REQ_ROTATE, 0, 0, 0, 0, 16'sh8000, 1'b0);
        send_request(REQ_VERTEX, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 1'b0);
        send_request(REQ_IDENTITY, 0, 0, 0, 0, 0, 1'b0);
        send_request(REQ_SCALE, 32'sh0002_0000, 32'sh0000_8000, 32'sh0001_0000,
                     -32'sh0001_0000, 0, 1'b0);
        send_request(REQ_VERTEX, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 1'b1);
        // scale that blows the matrix up, sticky flag must follow
        send_request(REQ_SCALE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                     32'sh7fff_ffff, 0, 1'b0);
        send_request(REQ_VERTEX, 0, 0, 0, 0, 0, 1'b0);
        // unused codes change nothing
        send_request(3'd5, 32'sh1234_5678, 0, 0, 0, 0, 1'b1);
        send_request(3'd6, 0, 0, 0, 0, 0, 1'b0);
        send_request(3'd7, 0, 0, 0, 0, 0, 1'b1);
        send_request(REQ_VERTEX, 32'sh0001_0000, 0, 0, 0, 0, 1'b1);
        send_request(REQ_IDENTITY, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff,
                     32'shffff_ffff, 16'shffff, 1'b1);
        send_request(REQ_VERTEX, 32'sh8000_0000, 32'sh7fff_ffff, 32'shffff_ffff,
                     32'shffff_ffff, 16'shffff, 1'b0);
    endtask

    // mostly short transform chains followed by vertex batches
    task automatic test_random(input int n_items);
        int          k;
        int          chain;
        logic [2:0]  rq;
        k = 0;
        while (k < n_items)
        begin
            if ($urandom_range(3) == 0)
            begin
                send_request(REQ_IDENTITY, $urandom(), $urandom(), $urandom(),
                             $urandom(), 16'($urandom()), 1'($urandom_range(1)));
                k++;
            end
            chain = $urandom_range(3);
            for (int i = 0; i < chain; i++)
            begin
                rq = req_t'($urandom_range(REQ_TRANSLATE, REQ_SCALE));
                if ($urandom_range(19) == 0)
                    rq = 3'($urandom_range(7));
                send_request(rq, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                             rand_angle(), 1'($urandom_range(1)));
                k++;
            end
            chain = $urandom_range(1, 5);
            for (int i = 0; i < chain; i++)
            begin
                send_request(REQ_VERTEX, rand_q16(), rand_q16(), $urandom(),
                             $urandom(), 16'($urandom()), i == chain - 1);
                k++;
            end
        end
    endtask

    // output side: random stall and result checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (vertex_q.size() == 0)
                begin
                    $error("result with nothing expected: out_x %0d out_y %0d",
                           out_x, out_y);
                    errors++;
                end
                else
                begin
                    vertex_t v;
                    v = vertex_q.pop_front();
                    if (out_x !== v.x)
                    begin
                        $error("out_x expected %0d actual %0d", v.x, out_x);
                        errors++;
                    end
                    if (out_y !== v.y)
                    begin
                        $error("out_y expected %0d actual %0d", v.y, out_y);
                        errors++;
                    end
                    if (batch_end !== v.last)
                    begin
                        $error("batch_end expected %0d actual %0d", v.last, batch_end);
                        errors++;
                    end
                    if (saturated !== v.sat)
                    begin
                        $error("saturated expected %0d actual %0d", v.sat, saturated);
                        errors++;
                    end
                    if (v.sat)
                        n_sat++;
                    n_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_ready  = 1'b0;
        req_type   = '0;
        arg_x      = '0;
        arg_y      = '0;
        point_x    = '0;
        point_y    = '0;
        angle      = '0;
        batch_last = 1'b0;
        errors     = 0;
        idle_cycles = 0;
        n_sent     = 0;
        n_checked  = 0;
        n_sat      = 0;
        send_idle_pct  = 13;
        recv_stall_pct = 86;
        load_identity();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(150);
        drain_results();
        // sender idles often while the receiver seldom stalls
        send_idle_pct  = 86;
        recv_stall_pct = 13;
        test_random(170);
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(170);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d requests of every type, checked %0d vertices (%0d saturated)",
                 n_sent, n_checked, n_sat);
        if (errors == 0 && vertex_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
